// ----- hdl/sm3_hash_core_macros.svh -----
// assertion macros for the sm3 hash core checker
`ifndef SM3_HASH_CORE_MACROS_SVH
`define SM3_HASH_CORE_MACROS_SVH

// property that must hold on every clock outside reset
`define SM3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication from a cause to an effect on the next clock
`define SM3_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

// ----- hdl/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the sm3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned DIGEST_WORDS = 8;
    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned ROUNDS       = 64;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // word pushed into the block buffer
    typedef enum logic [1:0] {
        SRC_MSG  = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_LENH = 2'd2,
        SRC_LENL = 2'd3
    } push_src_t;

    // commands from the controller
    typedef struct packed {
        logic      push;
        push_src_t src;
        logic      pad_lead;
        logic      cap_word;
        logic      load_work;
        logic      round;
        logic      fold;
        logic      init;
        logic      shift_out;
    } sm3_cmd_t;

    // status to the controller
    typedef struct packed {
        logic       buf_full;
        logic [3:0] fill;
        logic       round_done;
    } sm3_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ----- hdl/sm3_datapath.sv -----
// ----------------------------------------------------------------------------
// sm3_datapath
// Block buffer with sliding expansion window, round registers, chain value,
// bit length counter and digest shift register.
// ----------------------------------------------------------------------------
module sm3_datapath
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sm3_cmd_t    cmd,
    input  logic [31:0] msg_word,
    input  logic [2:0]  valid_bytes,
    input  logic        msg_last,
    output sm3_stat_t   stat,
    output logic [31:0] digest_word
);

    logic [31:0]  win_reg [BLOCK_WORDS];
    logic [31:0]  work_reg [8];
    logic [255:0] chain_reg;
    logic [255:0] out_reg;
    logic [63:0]  len_reg;
    logic [4:0]   fill_reg;
    logic [5:0]   round_reg;
    logic [31:0]  word_reg;
    logic [2:0]   vb_reg;
    logic         last_reg;

    logic [31:0] push_word;
    logic [31:0] keep;
    logic [31:0] pad;
    logic [2:0]  vb_eff;
    logic [31:0] ff, gg, tj, ss1, ss2, tt1, tt2, a12, wnew;
    logic [63:0] len_add;

    // clamp valid bytes, full word when not last
    always_comb
    begin
        if (!last_reg || vb_reg > 3'd4)
            vb_eff = 3'd4;
        else
            vb_eff = vb_reg;
        case (vb_eff)
            3'd0:    begin keep = 32'h0;        pad = {PAD_BYTE, 24'h0}; end
            3'd1:    begin keep = 32'hff000000; pad = {8'h0, PAD_BYTE, 16'h0}; end
            3'd2:    begin keep = 32'hffff0000; pad = {16'h0, PAD_BYTE, 8'h0}; end
            3'd3:    begin keep = 32'hffffff00; pad = {24'h0, PAD_BYTE}; end
            default: begin keep = 32'hffffffff; pad = 32'h0; end
        endcase
        len_add = {58'd0, vb_eff, 3'd0};
    end

    // word source for a buffer push
    always_comb
    begin
        case (cmd.src)
            SRC_MSG:  push_word = (word_reg & keep) | pad;
            SRC_PAD:  push_word = cmd.pad_lead ? {PAD_BYTE, 24'h0} : 32'h0;
            SRC_LENH: push_word = len_reg[63:32];
            SRC_LENL: push_word = len_reg[31:0];
            default:  push_word = 32'h0;
        endcase
    end

    // round logic
    always_comb
    begin
        tj  = (round_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(work_reg[0], 5'd12);
        if (round_reg < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        ss1  = rotl(a12 + work_reg[4] + rotl(tj, round_reg[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        tt1  = ff + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2  = gg + work_reg[7] + ss1 + win_reg[0];
        wnew = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
             ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // buffer and work registers, no reset on payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap_word)
        begin
            word_reg <= msg_word;
            vb_reg   <= valid_bytes;
            last_reg <= msg_last;
        end
        if (cmd.push)
            win_reg[fill_reg[3:0]] <= push_word;
        else if (cmd.round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[BLOCK_WORDS - 1] <= wnew;
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[255 - 32 * i -: 32];
        end
        else if (cmd.round)
        begin
            work_reg[0] <= tt1;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= rotl(work_reg[1], 5'd9);
            work_reg[3] <= work_reg[2];
            work_reg[4] <= perm0(tt2);
            work_reg[5] <= work_reg[4];
            work_reg[6] <= rotl(work_reg[5], 5'd19);
            work_reg[7] <= work_reg[6];
        end
        if (cmd.fold)
            out_reg <= chain_reg ^ {work_reg[0], work_reg[1], work_reg[2], work_reg[3],
                                    work_reg[4], work_reg[5], work_reg[6], work_reg[7]};
        else if (cmd.shift_out)
            out_reg <= {out_reg[223:0], 32'h0};
    end

    // control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= SM3_IV;
            len_reg   <= '0;
            fill_reg  <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                chain_reg <= SM3_IV;
                len_reg   <= '0;
            end
            else
            begin
                if (cmd.fold)
                    chain_reg <= chain_reg ^ {work_reg[0], work_reg[1], work_reg[2],
                                              work_reg[3], work_reg[4], work_reg[5],
                                              work_reg[6], work_reg[7]};
                if (cmd.push && cmd.src == SRC_MSG)
                    len_reg <= len_reg + len_add;
            end
            if (cmd.push)
                fill_reg <= fill_reg + 5'd1;
            else if (cmd.fold)
                fill_reg <= '0;
            if (cmd.round)
                round_reg <= round_reg + 6'd1;
        end
    end

    assign stat.buf_full   = fill_reg[4];
    assign stat.fill       = fill_reg[3:0];
    assign stat.round_done = (round_reg == 6'(ROUNDS - 1));
    assign digest_word     = out_reg[255:224];

endmodule

// ----- hdl/sm3_ctrl.sv -----
// ----------------------------------------------------------------------------
// sm3_ctrl
// Sequencer: takes words, pads the final block, runs 64 rounds per block
// and hands out eight digest words.
// ----------------------------------------------------------------------------
module sm3_ctrl
    import sm3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      msg_last,
    input  logic [2:0] valid_bytes,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      digest_last,
    input  sm3_stat_t stat,
    output sm3_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PUSH  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_PAD   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;    // 0 msg, 1 extra 0x80, 2 zero fill, 3 length
    logic       fin_reg, fin_next;        // message ended, padding in progress
    logic       full_reg, full_next;      // last word had four bytes
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        fin_next   = fin_reg;
        full_next  = full_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_word = 1'b1;
                    fin_next     = msg_last;
                    full_next    = !msg_last || valid_bytes >= 3'd4;
                    state_next   = ST_PUSH;
                end
            end
            // push the captured word
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                cmd.src    = SRC_MSG;
                phase_next = (fin_reg && full_reg) ? 2'd1 : 2'd2;
                state_next = (stat.fill == 4'd15) ? ST_LOAD : (fin_reg ? ST_PAD : ST_IDLE);
            end
            // padding words after the last message word
            ST_PAD:
            begin
                cmd.push = 1'b1;
                if (phase_reg == 2'd1)
                begin
                    cmd.src      = SRC_PAD;
                    cmd.pad_lead = 1'b1;
                end
                else if (stat.fill == 4'd14)
                    cmd.src = SRC_LENH;
                else if (stat.fill == 4'd15 && phase_reg == 2'd3)
                    cmd.src = SRC_LENL;
                else
                    cmd.src = SRC_PAD;
                if (phase_reg == 2'd1)
                    phase_next = 2'd2;
                if (stat.fill == 4'd15)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.round_done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (phase_reg == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    cnt_next      = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(DIGEST_WORDS - 1))
                    begin
                        cmd.init   = 1'b1;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // the high length word marks the closing block
        if (cmd.push && cmd.src == SRC_LENH)
            phase_next = 2'd3;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            fin_reg   <= 1'b0;
            full_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            full_reg  <= full_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_last = (state_reg == ST_OUT) && (cnt_reg == 3'(DIGEST_WORDS - 1));

endmodule

// ----- hdl/sm3_hash_core.sv -----
// ----------------------------------------------------------------------------
// sm3_hash_core
// SM3 hash of a word stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Input channel: msg_word, valid_bytes, msg_last under in_valid/in_ready.
// Words are big-endian; only the word with msg_last may carry fewer than
// four valid bytes. in_ready is low while a taken word is pushed; the
// sixteenth word of a block starts a compression (load, 64 rounds, fold)
// during which in_ready stays low, so a long message is paced by the
// single round unit doing one round per cycle.
// After the last word the block appends 0x80, zero fill and the 64-bit bit
// length over one or two blocks, then raises out_valid with digest_word V0
// first; digest_last marks the eighth word. A stalled receiver holds the
// current word; the next message is taken once the eighth word transfers.
// Reset loads the initial vector and clears the length and fill counters.
// ----------------------------------------------------------------------------
module sm3_hash_core
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] msg_word,
    input  logic [2:0]  valid_bytes,
    input  logic        msg_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        digest_last
);

    sm3_cmd_t  cmd;
    sm3_stat_t stat;

    sm3_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .msg_last    (msg_last),
        .valid_bytes (valid_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_last (digest_last),
        .stat        (stat),
        .cmd         (cmd)
    );

    sm3_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg_word    (msg_word),
        .valid_bytes (valid_bytes),
        .msg_last    (msg_last),
        .stat        (stat),
        .digest_word (digest_word)
    );

endmodule

// ----- hdl/sm3_checker.sv -----
// ----------------------------------------------------------------------------
// sm3_checker
// Port-level checks of the sm3 hash core.
// ----------------------------------------------------------------------------
`include "sm3_hash_core_macros.svh"

module sm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic        digest_last
);

    // no input taken while a digest is pending
    `SM3_ASSERT(a_no_in_during_out, !(in_ready && out_valid), "input ready during digest")
    // digest last only with out valid
    `SM3_ASSERT(a_last_qual, !digest_last || out_valid, "digest_last without valid")
    // a stalled digest word holds
    `SM3_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word),
                     "digest word changed under stall")
    // after the last word transfers the output drops
    `SM3_ASSERT_NEXT(a_end, out_valid && out_ready && digest_last, !out_valid,
                     "output valid after final word")

endmodule

bind sm3_hash_core sm3_checker u_sm3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .digest_last (digest_last)
);
